/* rtl/core/sdn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sdn_pkg;

  // Field widths of the input and result beats.
  localparam int DIM_W      = 8;
  localparam int POLY_W     = 9;
  localparam int INIT_W     = 8;
  localparam int NUM_INIT   = 8;
  localparam int INIT_SEL_W = 3;
  localparam int IDX_W      = 6;
  localparam int DIR_W      = 64;
  localparam int DEG_W      = 4;

  // Configuration port.
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PRECISION   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_VECTORS = 2'd1;

  localparam logic [CFG_W-1:0] PRECISION_RESET   = 7'd64;
  localparam logic [CFG_W-1:0] NUM_VECTORS_RESET = 7'd32;
  localparam logic [CFG_W-1:0] PRECISION_MIN     = 7'd8;

  typedef struct packed {
    logic [DIM_W-1:0]  dimension;
    logic [POLY_W-1:0] polynomial;
    logic [INIT_W-1:0] init_0;
    logic [INIT_W-1:0] init_1;
    logic [INIT_W-1:0] init_2;
    logic [INIT_W-1:0] init_3;
    logic [INIT_W-1:0] init_4;
    logic [INIT_W-1:0] init_5;
    logic [INIT_W-1:0] init_6;
    logic [INIT_W-1:0] init_7;
  } in_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] dimension_tag;
    logic [IDX_W-1:0] vector_index;
    logic [DIR_W-1:0] direction;
    logic             last;
  } out_item_t;

  // Sequencer states.
  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // Control from the sequencer to the recurrence unit.
  typedef struct packed {
    logic             start;
    logic             advance;
    logic             last;
    logic [IDX_W-1:0] step;
  } seq_ctl_t;

  // Position of the highest set bit above bit zero; zero when there is none.
  function automatic logic [DEG_W-1:0] poly_degree(input logic [POLY_W-1:0] poly);
    logic [DEG_W-1:0] deg;
    deg = '0;
    for (int k = 1; k < POLY_W; k++) begin
      if (poly[k]) begin
        deg = DEG_W'(k);
      end
    end
    return deg;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/sdn_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one dimension description per beat.
interface sdn_in_if;
  logic              valid;
  logic              ready;
  sdn_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// Result channel: one direction number per beat.
interface sdn_out_if;
  logic               valid;
  logic               ready;
  sdn_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/sdn_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module sdn_cfg #(
  parameter int MAX_VECTORS = 64,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sdn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdn_pkg::CFG_W-1:0]     cfg_data,
  output logic [sdn_pkg::CFG_W-1:0]     prec,
  output logic [sdn_pkg::CFG_W-1:0]     count
);
  import sdn_pkg::*;

  logic [CFG_W-1:0] precision;
  logic [CFG_W-1:0] num_vectors;

  // Register file; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      precision   <= PRECISION_RESET;
      num_vectors <= NUM_VECTORS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRECISION:   precision   <= cfg_data;
        REG_NUM_VECTORS: num_vectors <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp precision into the range the shifter supports.
  always_comb begin
    if (precision < PRECISION_MIN) begin
      prec = PRECISION_MIN;
    end else if ({1'b0, precision} > 8'(VALUE_WIDTH)) begin
      prec = CFG_W'(VALUE_WIDTH);
    end else begin
      prec = precision;
    end
  end

  // A count of zero means one; large counts stop at the maximum.
  always_comb begin
    if (num_vectors == '0) begin
      count = CFG_W'(1);
    end else if ({1'b0, num_vectors} > 8'(MAX_VECTORS)) begin
      count = CFG_W'(MAX_VECTORS);
    end else begin
      count = num_vectors;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sdn_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module sdn_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      out_free,
  input  logic [sdn_pkg::CFG_W-1:0] count,
  output logic                      in_ready,
  output sdn_pkg::seq_ctl_t         ctl
);
  import sdn_pkg::*;

  seq_state_t       state;
  seq_state_t       state_next;
  logic [IDX_W-1:0] step;
  logic [CFG_W-1:0] count_q;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: begin
        if (in_valid) begin
          state_next = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (ctl.advance && ctl.last) begin
          state_next = SEQ_IDLE;
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready    = 1'b0;
    ctl.start   = 1'b0;
    ctl.advance = 1'b0;
    ctl.step    = step;
    ctl.last    = ({1'b0, step} + CFG_W'(1)) == count_q;
    unique case (state)
      SEQ_IDLE: begin
        in_ready  = 1'b1;
        ctl.start = in_valid;
      end
      SEQ_RUN: begin
        ctl.advance = out_free;
      end
      default: ;
    endcase
  end

  // Step counter and the count latched for this dimension.
  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= '0;
      count_q <= CFG_W'(1);
    end else if (ctl.start) begin
      step    <= '0;
      count_q <= count;
    end else if (ctl.advance) begin
      step    <= step + IDX_W'(1);
    end
  end

`ifndef SYNTH
  // A new dimension is never taken while numbers are still being produced.
  a_no_start_in_run: assert property (@(posedge clk) disable iff (rst)
    !(ctl.start && ctl.advance))
    else $error("sdn_seq: start during a run");

  // The final number of a dimension returns the sequencer to idle.
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (ctl.advance && ctl.last) |=> (state == SEQ_IDLE))
    else $error("sdn_seq: run did not end after the final number");

  // The step never runs past the latched count.
  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == SEQ_RUN) |-> ({1'b0, step} < count_q))
    else $error("sdn_seq: step beyond count");

  // Every run starts from step zero.
  a_step_restart: assert property (@(posedge clk) disable iff (rst)
    ctl.start |=> (step == '0))
    else $error("sdn_seq: step not cleared at start");
`endif

endmodule

`default_nettype wire

/* rtl/core/sdn_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module sdn_unit #(
  parameter int HIST_DEPTH  = 8,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sdn_pkg::seq_ctl_t         ctl,
  input  sdn_pkg::in_item_t         item,
  input  logic [sdn_pkg::CFG_W-1:0] prec,
  output logic [sdn_pkg::DIM_W-1:0] tag,
  output logic [VALUE_WIDTH-1:0]    value
);
  import sdn_pkg::*;

  // Context of the dimension in work.
  logic [INIT_W-1:0]      inits [NUM_INIT];
  logic [CFG_W-1:0]       prec_q;
  logic [DEG_W-1:0]       deg;
  logic [HIST_DEPTH-1:0]  tap;
  logic [HIST_DEPTH-1:0]  coef;

  // Most recent numbers, newest in entry zero.
  logic [VALUE_WIDTH-1:0] hist [HIST_DEPTH];

  logic [DEG_W-1:0]       deg_raw;
  logic [DEG_W-1:0]       deg_in;
  logic [HIST_DEPTH-1:0]  tap_in;
  logic [HIST_DEPTH-1:0]  coef_in;
  logic [DEG_W-1:0]       coef_pos;

  logic [CFG_W-1:0]       lsh;
  logic [VALUE_WIDTH-1:0] init_val;
  logic [VALUE_WIDTH-1:0] tap_val;
  logic [VALUE_WIDTH-1:0] rec_val;

  // Degree, clamped to the history depth.
  always_comb begin
    deg_raw = poly_degree(item.polynomial);
    if ({1'b0, deg_raw} > (DEG_W + 1)'(HIST_DEPTH)) begin
      deg_in = DEG_W'(HIST_DEPTH);
    end else begin
      deg_in = deg_raw;
    end
  end

  // Tap selecting the entry d places back, and the coefficient of each entry.
  always_comb begin
    coef_pos = '0;
    for (int k = 0; k < HIST_DEPTH; k++) begin
      tap_in[k] = ((DEG_W + 1)'(k) + (DEG_W + 1)'(1)) == {1'b0, deg_in};
      coef_pos  = deg_in - DEG_W'(k) - DEG_W'(1);
      coef_in[k] = ((DEG_W + 1)'(k) < {1'b0, deg_in}) && item.polynomial[coef_pos];
    end
  end

  // Capture the dimension at start.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      tag      <= item.dimension;
      prec_q   <= prec;
      deg      <= deg_in;
      tap      <= tap_in;
      coef     <= coef_in;
      inits[0] <= item.init_0;
      inits[1] <= item.init_1;
      inits[2] <= item.init_2;
      inits[3] <= item.init_3;
      inits[4] <= item.init_4;
      inits[5] <= item.init_5;
      inits[6] <= item.init_6;
      inits[7] <= item.init_7;
    end
  end

  // History: cleared for each dimension, shifted once per number.
  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      for (int k = 0; k < HIST_DEPTH; k++) begin
        hist[k] <= '0;
      end
    end else if (ctl.advance) begin
      hist[0] <= value;
      for (int k = 1; k < HIST_DEPTH; k++) begin
        hist[k] <= hist[k-1];
      end
    end
  end

  // Initial number: the seed placed below the precision's top bit.
  always_comb begin
    lsh      = prec_q - CFG_W'(ctl.step) - CFG_W'(1);
    init_val = VALUE_WIDTH'(inits[ctl.step[INIT_SEL_W-1:0]]) << lsh;
  end

  // Recurrence: entry d places back shifted by d, XORed with the selected entries.
  always_comb begin
    tap_val = '0;
    for (int k = 0; k < HIST_DEPTH; k++) begin
      tap_val = tap_val | (hist[k] & {VALUE_WIDTH{tap[k]}});
    end
    rec_val = tap_val >> deg;
    for (int k = 0; k < HIST_DEPTH; k++) begin
      rec_val = rec_val ^ (hist[k] & {VALUE_WIDTH{coef[k]}});
    end
  end

  // Choose the number for this step.
  always_comb begin
    if (deg == '0) begin
      value = '0;
    end else if ({1'b0, ctl.step} < {3'b000, deg}) begin
      value = init_val;
    end else begin
      value = rec_val;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sobol_direction_numbers.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Role    Beat contents
// cfg_*     write   register index and data, precision and num_vectors
// in_ch     sink    one dimension: tag, polynomial, eight seed values
// out_ch    source  one direction number: tag, index, value, last flag
//
// A dimension is loaded while the sequencer idles; the single recurrence unit
// then makes one direction number per cycle while the output register is free.
// Reset sets precision to 64 and num_vectors to 32; no clearing pass is needed.
// A stalled result holds the unit; in_ch is ready only between dimensions,
// and a new dimension can be taken while the final result still waits.

module sobol_direction_numbers #(
  parameter int HIST_DEPTH  = 8,
  parameter int MAX_VECTORS = 64,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sdn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdn_pkg::CFG_W-1:0]     cfg_data,
  sdn_in_if.sink                        in_ch,
  sdn_out_if.source                     out_ch
);
  import sdn_pkg::*;

  logic [CFG_W-1:0]       prec;
  logic [CFG_W-1:0]       count;
  seq_ctl_t               ctl;
  logic [DIM_W-1:0]       tag;
  logic [VALUE_WIDTH-1:0] value;
  logic                   out_valid;
  out_item_t              out_item;
  logic                   out_free;

  sdn_cfg #(
    .MAX_VECTORS (MAX_VECTORS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .prec      (prec),
    .count     (count)
  );

  sdn_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .count    (count),
    .in_ready (in_ch.ready),
    .ctl      (ctl)
  );

  sdn_unit #(
    .HIST_DEPTH  (HIST_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_unit (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .item  (in_ch.payload),
    .prec  (prec),
    .tag   (tag),
    .value (value)
  );

  // Output register: free when empty or when its beat is taken.
  assign out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      out_item.dimension_tag <= tag;
      out_item.vector_index  <= ctl.step;
      out_item.direction     <= DIR_W'(value);
      out_item.last          <= ctl.last;
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

endmodule

`default_nettype wire

/* verif/tb_sobol_direction_numbers.sv */
`timescale 1ns / 1ps

module tb_sobol_direction_numbers;
  import sdn_pkg::*;

  localparam int HIST_DEPTH  = 8;
  localparam int MAX_VECTORS = 64;
  localparam int VALUE_WIDTH = 64;
  localparam int IDLE_MAX    = 13;
  localparam int SHOW_LIMIT  = 10;
  localparam int HOLD_LONG   = 200;

  // Register indexes past the defined list; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  sdn_in_if  in_ch ();
  sdn_out_if out_ch ();

  sobol_direction_numbers #(
    .HIST_DEPTH  (HIST_DEPTH),
    .MAX_VECTORS (MAX_VECTORS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Our copy of the configuration registers.
  logic [CFG_W-1:0] cur_precision;
  logic [CFG_W-1:0] cur_num_vectors;

  // Direction numbers still owed by the block, oldest first.
  out_item_t pending_dirs[$];

  int  errors;
  int  shown;
  bit  idle_off;
  int  hold_cycles;

  // Free-running clock, 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Per-beat idle count for either side; zero while idling is switched off.
  function automatic int draw_gap();
    return idle_off ? 0 : $urandom_range(IDLE_MAX, 0);
  endfunction

  // Work out every direction number that one dimension produces.
  function automatic void predict_directions(input in_item_t item);
    logic [VALUE_WIDTH-1:0] hist [HIST_DEPTH];
    logic [VALUE_WIDTH-1:0] v;
    logic [INIT_W-1:0]      seeds [NUM_INIT];
    out_item_t              res;
    int                     prec;
    int                     count;
    int                     deg;

    prec  = cur_precision;
    count = cur_num_vectors;
    if (prec < 8) prec = 8;
    if (prec > VALUE_WIDTH) prec = VALUE_WIDTH;
    if (count < 1) count = 1;
    if (count > MAX_VECTORS) count = MAX_VECTORS;

    // Degree is the highest set coefficient above the constant term.
    deg = 0;
    for (int k = 1; k < POLY_W; k++) begin
      if (item.polynomial[k]) deg = k;
    end
    if (deg > HIST_DEPTH) deg = HIST_DEPTH;

    seeds = '{item.init_0, item.init_1, item.init_2, item.init_3,
              item.init_4, item.init_5, item.init_6, item.init_7};
    for (int k = 0; k < HIST_DEPTH; k++) hist[k] = '0;

    for (int i = 0; i < count; i++) begin
      if (deg == 0) begin
        v = '0;
      end else if (i < deg) begin
        v = VALUE_WIDTH'(seeds[i]) << (prec - 1 - i);
      end else begin
        // hist[k] holds the number produced k+1 steps ago.
        v = hist[deg-1] >> deg;
        for (int j = 1; j <= deg; j++) begin
          if (item.polynomial[deg-j]) v ^= hist[j-1];
        end
      end
      for (int k = HIST_DEPTH - 1; k > 0; k--) hist[k] = hist[k-1];
      hist[0] = v;

      res.dimension_tag = item.dimension;
      res.vector_index  = IDX_W'(i);
      res.direction     = v;
      res.last          = (i == count - 1);
      pending_dirs.push_back(res);
    end
  endfunction

  task automatic report_mismatch(input string what, input out_item_t want,
                                 input out_item_t got);
    errors++;
    if (shown < SHOW_LIMIT) begin
      shown++;
      $display("Mismatch at %0t (%s): expected tag %0d idx %0d dir %h last %b",
               $realtime, what, want.dimension_tag, want.vector_index,
               want.direction, want.last);
      $display("    got tag %0d idx %0d dir %h last %b",
               got.dimension_tag, got.vector_index, got.direction, got.last);
    end
  endtask

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin : check_results
    out_item_t want;
    out_item_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (pending_dirs.size() == 0) begin
        want = '0;
        report_mismatch("no result expected", want, got);
      end else begin
        want = pending_dirs.pop_front();
        if (got.dimension_tag !== want.dimension_tag ||
            got.vector_index !== want.vector_index ||
            got.direction !== want.direction ||
            got.last !== want.last) begin
          report_mismatch("field differs", want, got);
        end
      end
    end
  end

  // Result receiver: random stalls per beat, plus a long hold-off on request.
  initial begin : drive_out_ready
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_cycles != 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
        repeat (stall) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
        end
      end else begin
        stall = draw_gap();
        repeat (stall) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
        end
        @(negedge clk);
        out_ch.ready <= 1'b1;
        @(posedge clk);
        while (!out_ch.valid) @(posedge clk);
      end
    end
  end

  // Offer one dimension beat after a random gap and predict on acceptance.
  task automatic send_dimension(input in_item_t item);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.payload <= item;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_directions(item);
  endtask

  // Stop offering, then let every owed result drain before touching registers.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_dirs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_PRECISION:   cur_precision = value;
      REG_NUM_VECTORS: cur_num_vectors = value;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CFG_W-1:0] prec, input logic [CFG_W-1:0] nvec);
    write_register(REG_PRECISION, prec);
    write_register(REG_NUM_VECTORS, nvec);
  endtask

  // Seeds are packed with init_0 in the top byte.
  function automatic in_item_t build_item(input logic [DIM_W-1:0] dim,
                                          input logic [POLY_W-1:0] poly,
                                          input logic [8*NUM_INIT-1:0] seeds);
    return {dim, poly, seeds};
  endfunction

  // Mostly well-formed dimensions: constant term set and odd seeds below
  // 2^(k+1). The remainder is unconstrained noise, degree-zero cases included.
  function automatic in_item_t random_dimension();
    logic [POLY_W-1:0]       poly;
    logic [8*NUM_INIT-1:0]   seeds;
    if ($urandom_range(3, 0) != 0) begin
      poly = POLY_W'($urandom_range(511, 2)) | POLY_W'(1);
      for (int k = 0; k < NUM_INIT; k++) begin
        seeds[8*NUM_INIT-1-8*k -: 8] = INIT_W'($urandom_range((2 << k) - 1, 0)) | 8'd1;
      end
    end else begin
      if ($urandom_range(15, 0) == 0) poly = POLY_W'($urandom_range(1, 0));
      else poly = POLY_W'($urandom_range(511, 0));
      seeds = {$urandom, $urandom};
    end
    return build_item(DIM_W'($urandom_range(255, 0)), poly, seeds);
  endfunction

  // Field extremes and the special cases, first under the reset settings.
  task automatic test_directed_cases();
    // Degree-zero polynomials give all-zero directions.
    send_dimension(build_item(8'd0, 9'd0, 64'hFFFF_FFFF_FFFF_FFFF));
    send_dimension(build_item(8'd255, 9'd1, 64'h0103_0507_090B_0D0F));
    // Low degrees, then degrees seven and eight.
    send_dimension(build_item(8'd1, 9'd2, 64'h0101_0101_0101_0101));
    send_dimension(build_item(8'd2, 9'd3, 64'h0100_0000_0000_0000));
    send_dimension(build_item(8'd3, 9'd7, 64'h0103_0000_0000_0000));
    send_dimension(build_item(8'd4, 9'h1FF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_dimension(build_item(8'd5, 9'h100, 64'h0103_0507_090B_0D0F));
    send_dimension(build_item(8'd6, 9'h11D, 64'h0103_0709_0F1D_2B55));
    send_dimension(build_item(8'd7, 9'h155, 64'hAA55_AA55_AA55_AA55));
    send_dimension(build_item(8'h80, 9'h0AA, 64'h0000_0000_0000_0000));
    wait_idle();

    // Narrowest precision with the longest run; oversized seeds keep high bits.
    set_config(7'd8, 7'd64);
    send_dimension(build_item(8'd10, 9'h1FF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_dimension(build_item(8'd11, 9'h013, 64'h0103_0507_090B_0D0F));
    wait_idle();

    // Precision below range saturates; fewer vectors than the degree.
    set_config(7'd0, 7'd3);
    send_dimension(build_item(8'd12, 9'h1CB, 64'h0103_0507_090B_0D0F));
    wait_idle();

    // A zero vector count acts as one.
    write_register(REG_NUM_VECTORS, 7'd0);
    send_dimension(build_item(8'd13, 9'h025, 64'h7F00_0000_0000_0000));
    wait_idle();

    // Both registers above range; seed bits shifted past the top are lost.
    set_config(7'd127, 7'd127);
    send_dimension(build_item(8'd14, 9'h1FF, 64'hFFFF_FFFF_FFFF_FFFF));
    wait_idle();

    // Writes to undefined indexes must leave the settings alone.
    write_register(REG_SPARE_2, 7'h7F);
    write_register(REG_SPARE_3, 7'h00);
    send_dimension(build_item(8'd15, 9'h089, 64'h0103_0507_090B_0D0F));
    wait_idle();
  endtask

  // Receiver stops for a long stretch while dimensions keep coming.
  task automatic test_output_backpressure();
    set_config(7'd64, 7'd16);
    idle_off    = 1'b1;
    hold_cycles = HOLD_LONG;
    for (int n = 0; n < 6; n++) send_dimension(random_dimension());
    idle_off = 1'b0;
    wait_idle();
  endtask

  // Random dimensions under a series of settings, extremes among them.
  task automatic test_random_dimensions();
    int prec_set [8];
    int nvec_set [8];
    prec_set = '{64, 8, 32, 0, 127, 17, 45, 64};
    nvec_set = '{64, 1, 12, 0, 127, 9, 20, 32};
    for (int p = 0; p < 10; p++) begin
      if (p < 8) begin
        set_config(CFG_W'(prec_set[p]), CFG_W'(nvec_set[p]));
      end else begin
        set_config(CFG_W'($urandom_range(127, 0)), CFG_W'($urandom_range(24, 1)));
      end
      // One phase runs with no idling on either side.
      idle_off = (p == 2);
      for (int n = 0; n < 38; n++) send_dimension(random_dimension());
      idle_off = 1'b0;
      wait_idle();
    end
  endtask

  initial begin : run_tests
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.payload   = '0;
    cur_precision   = PRECISION_RESET;
    cur_num_vectors = NUM_VECTORS_RESET;
    errors          = 0;
    shown           = 0;
    idle_off        = 1'b0;
    hold_cycles     = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_output_backpressure();
    test_random_dimensions();

    wait_idle();
    repeat (MAX_VECTORS + 8) @(posedge clk);
    if (errors == 0 && pending_dirs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin : watchdog
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
